@@ hdl/block_table_heap_allocator_assert.svh @@
// Assertion macros of the allocator RTL.
// Included by btha_ctrl, which checks its own control logic.
`ifndef BLOCK_TABLE_HEAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_TABLE_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/btha_pkg.sv @@
// Shared types and constants of the block table heap allocator.
// No dependencies; imported by every allocator module.
`default_nettype none

package btha_pkg;

  localparam int NUM_BLOCKS_DEF  = 1024;
  localparam int BLOCK_BYTES_DEF = 4096;

  // Table entry layout
  localparam int ENTRY_W        = 3;
  localparam int MARK_TAKEN_BIT = 0;
  localparam int MARK_FIRST_BIT = 1;
  localparam int MARK_NEXT_BIT  = 2;

  localparam int BLOCK_COUNT_W = 11;
  localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_BADFREE = 2'd2,
    STAT_RSVD    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_HEAP_BASE   = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_idx_t;

  // Divider result toward the controller
  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic        rem_nz;
  } div_res_t;

endpackage

`default_nettype wire

@@ hdl/block_table_heap_allocator.sv @@
// First-fit block table heap allocator. After reset the block sweeps the whole
// table clear, one entry a cycle, before in_tready rises; configuration writes
// are taken throughout. One item is in work at a time, and BLOCK_BYTES must be
// a power of two. Allocate registers the size-to-blocks shift, then scans the
// table in order through the single read port, up to the effective block count;
// a hit marks the run block by block, then forms the address by a multiply and
// an add before the result step, while a failed scan or a zero or oversized
// request goes straight to the result step. Free registers the offset shift and
// clears the chain block by block, or goes straight to the result step when the
// address lies below the heap base. Clear sweeps the table as after reset, and
// the unused mode goes straight to the result step. A finished result waits in an
// output register without blocking the input; in_tready rises again in the same
// cycle as out_tvalid. Top level: configuration registers and module wiring;
// depends on btha_pkg, btha_ctrl, btha_div and btha_mem.
`default_nettype none

module block_table_heap_allocator
  import btha_pkg::*;
#(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,     // [31:0] size_bytes, [63:32] free_address
  input  wire logic [1:0]  in_tuser,     // [1:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [31:0] address
  output logic [1:0]       out_tuser     // [1:0] status
);

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic [31:0]              heap_base_r;
  logic [BLOCK_COUNT_W-1:0] block_count_r;

  div_res_t           div_res;
  logic               div_start;
  logic [31:0]        div_dividend;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;
  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [ENTRY_W-1:0] mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r   <= '0;
      block_count_r <= BLOCK_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEAP_BASE:   heap_base_r   <= cfg_wr_data;
        CFG_BLOCK_COUNT: block_count_r <= cfg_wr_data[BLOCK_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  btha_ctrl #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .heap_base    (heap_base_r),
    .block_count  (block_count_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_res      (div_res),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data)
  );

  btha_div #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .res      (div_res)
  );

  btha_mem #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

@@ hdl/btha_mem.sv @@
// Block table storage: one write port, one read port, registered read data.
// Depends on btha_pkg for the entry width.
`default_nettype none

module btha_mem
  import btha_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [NUM_BLOCKS];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hdl/btha_div.sv @@
// Block-size division of a 32-bit value: shift for the quotient, mask for the
// remainder, both registered. Depends on btha_pkg for the result struct.
`default_nettype none

module btha_div
  import btha_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  output div_res_t         res
);

  // Block size must be a power of two; the module does not enforce it
  localparam int          SHIFT    = $clog2(BLOCK_BYTES);
  localparam logic [31:0] REM_MASK = 32'(BLOCK_BYTES - 1);

  logic        done_r;
  logic [31:0] quo_r, quo_nxt;
  logic        rem_nz_r, rem_nz_nxt;

  assign quo_nxt    = dividend >> SHIFT;
  assign rem_nz_nxt = ((dividend & REM_MASK) != 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
    if (start) begin
      quo_r    <= quo_nxt;
      rem_nz_r <= rem_nz_nxt;
    end
  end

  assign res.done   = done_r;
  assign res.quo    = quo_r;
  assign res.rem_nz = rem_nz_r;

endmodule

`default_nettype wire

@@ hdl/btha_ctrl.sv @@
// Allocator sequencer: table scan, run marking, chain release, clearing pass,
// result register. Depends on btha_pkg and the assertion macro header.
`default_nettype none

`include "block_table_heap_allocator_assert.svh"

module btha_ctrl
  import btha_pkg::*;
#(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [31:0]              heap_base,
  input  wire logic [BLOCK_COUNT_W-1:0] block_count,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [63:0]              in_tdata,
  input  wire logic [1:0]               in_tuser,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [31:0]                   out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          div_start,
  output logic [31:0]                   div_dividend,
  input  div_res_t                      div_res,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [ENTRY_W-1:0]            mem_wr_data,
  output logic                          mem_rd_en,
  output logic [AW-1:0]                 mem_rd_addr,
  input  wire logic [ENTRY_W-1:0]       mem_rd_data
);

  localparam int CW   = $clog2(NUM_BLOCKS + 1);
  localparam int CMPW = (CW > BLOCK_COUNT_W) ? CW : BLOCK_COUNT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);
  localparam logic [31:0]   BB32     = 32'(BLOCK_BYTES);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_SCAN, S_WRITE, S_MUL, S_ADD, S_FREE, S_RESP
  } state_t;

  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic          clr_emit_r, clr_emit_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [CW-1:0] need_r, need_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  status_t       res_stat_r, res_stat_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [31:0]   out_addr_r, out_addr_nxt;
  status_t       out_stat_r, out_stat_nxt;

  logic [CMPW-1:0] cnt_wide;
  logic [CW-1:0]   cnt;
  logic [32:0]     need_full;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   run_inc;
  logic            entry_busy;
  logic            more;
  logic [31:0]     size_bytes;
  logic [31:0]     free_address;

  assign size_bytes   = in_tdata[31:0];
  assign free_address = in_tdata[63:32];

  // Effective table size: block_count clipped to the table depth
  assign cnt_wide = (CMPW'(block_count) < CMPW'(NUM_BLOCKS)) ? CMPW'(block_count)
                                                             : CMPW'(NUM_BLOCKS);
  assign cnt       = CW'(cnt_wide);
  assign need_full = {1'b0, div_res.quo} + 33'(div_res.rem_nz);
  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign run_inc   = run_r + CW'(1);
  assign entry_busy = (mem_rd_data != '0);
  assign more       = mem_rd_data[MARK_NEXT_BIT];

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    clr_emit_nxt   = clr_emit_r;
    clr_idx_nxt    = clr_idx_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    k_nxt          = k_r;
    run_nxt        = run_r;
    need_nxt       = need_r;
    res_addr_nxt   = res_addr_r;
    res_stat_nxt   = res_stat_r;
    out_tvalid_nxt = out_tvalid_r;
    out_addr_nxt   = out_addr_r;
    out_stat_nxt   = out_stat_r;
    div_start      = 1'b0;
    div_dividend   = size_bytes;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = idx_r;
    mem_wr_data    = '0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = idx_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_idx_r;
        if (clr_idx_r == LAST_IDX) begin
          res_addr_nxt = '0;
          res_stat_nxt = STAT_OK;
          state_nxt    = clr_emit_r ? S_RESP : S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = mode_t'(in_tuser);
          case (mode_t'(in_tuser))
            MODE_ALLOC: begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
            MODE_FREE: begin
              if (free_address < heap_base) begin
                res_addr_nxt = '0;
                res_stat_nxt = STAT_BADFREE;
                state_nxt    = S_RESP;
              end else begin
                div_start    = 1'b1;
                div_dividend = free_address - heap_base;
                state_nxt    = S_DIV;
              end
            end
            MODE_CLEAR: begin
              clr_idx_nxt  = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            default: begin
              res_addr_nxt = '0;
              res_stat_nxt = STAT_OK;
              state_nxt    = S_RESP;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          res_addr_nxt = '0;
          if (mode_r == MODE_ALLOC) begin
            if (need_full == '0 || need_full > 33'(cnt)) begin
              res_stat_nxt = STAT_NOSPACE;
              state_nxt    = S_RESP;
            end else begin
              need_nxt    = CW'(need_full);
              run_nxt     = '0;
              idx_nxt     = '0;
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              state_nxt   = S_SCAN;
            end
          end else begin
            if (div_res.rem_nz || div_res.quo >= 32'(cnt)) begin
              res_stat_nxt = STAT_BADFREE;
              state_nxt    = S_RESP;
            end else begin
              idx_nxt     = AW'(div_res.quo);
              mem_rd_en   = 1'b1;
              mem_rd_addr = AW'(div_res.quo);
              state_nxt   = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        // mem_rd_data holds entry idx_r; while the scan goes on, the next read goes out this cycle
        if (!entry_busy && run_inc == need_r) begin
          start_nxt = AW'(idx_inc - need_r);
          k_nxt     = AW'(idx_inc - need_r);
          end_nxt   = idx_r;
          state_nxt = S_WRITE;
        end else begin
          run_nxt = entry_busy ? '0 : run_inc;
          if (idx_inc < cnt) begin
            idx_nxt     = AW'(idx_inc);
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(idx_inc);
          end else begin
            res_addr_nxt = '0;
            res_stat_nxt = STAT_NOSPACE;
            state_nxt    = S_RESP;
          end
        end
      end
      S_WRITE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = k_r;
        mem_wr_data[MARK_TAKEN_BIT] = 1'b1;
        mem_wr_data[MARK_FIRST_BIT] = (k_r == start_r);
        mem_wr_data[MARK_NEXT_BIT]  = (k_r != end_r);
        if (k_r == end_r) begin
          state_nxt = S_MUL;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      S_MUL: begin
        res_addr_nxt = 32'(start_r) * BB32;
        state_nxt    = S_ADD;
      end
      S_ADD: begin
        res_addr_nxt = res_addr_r + heap_base;
        res_stat_nxt = STAT_OK;
        state_nxt    = S_RESP;
      end
      S_FREE: begin
        // Clear this block, fetch the next one while the chain goes on
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r;
        if (more && idx_inc < cnt) begin
          idx_nxt     = AW'(idx_inc);
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(idx_inc);
        end else begin
          res_addr_nxt = '0;
          res_stat_nxt = STAT_OK;
          state_nxt    = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_stat_nxt   = res_stat_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_idx_r    <= '0;
      clr_emit_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      clr_emit_r   <= (state_nxt == S_CLR) ? clr_emit_nxt : 1'b0;
      out_tvalid_r <= out_tvalid_nxt;
    end
    mode_r     <= mode_nxt;
    idx_r      <= idx_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    k_r        <= k_nxt;
    run_r      <= run_nxt;
    need_r     <= need_nxt;
    res_addr_r <= res_addr_nxt;
    res_stat_r <= res_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_stat_r;

  `BTHA_ASSERT_IMP(a_no_same_entry, clk, rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "read and write hit the same table entry")
  `BTHA_ASSERT_IMP(a_write_in_run, clk, rst_n, state_r == S_WRITE, k_r >= start_r && k_r <= end_r, "run marking left its run")
  `BTHA_ASSERT_IMP(a_div_owner, clk, rst_n, div_res.done, state_r == S_DIV, "divider finished with no waiting request")
  `BTHA_ASSERT_NXT(a_scan_read_only, clk, rst_n, state_r == S_SCAN, !(state_r == S_SCAN && mem_wr_en), "table written during scan")

endmodule

`default_nettype wire
